>>> rtl/core/bed_pkg.sv
package bed_pkg;

	// Sizes
	localparam int NUM_BUTTONS = 8;
	localparam int MAX_RESULTS = 8;
	localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
	localparam int TIME_W      = 32;
	localparam int MS_W        = 16;
	localparam int MASK_W      = 8;
	localparam int MASK_IDX_W  = $clog2(MASK_W);
	localparam int BTN_W       = 3;
	localparam int EV_W        = 3;
	localparam int REG_IDX_W   = 2;

	// Input operation codes
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Event codes
	localparam logic [EV_W-1:0] EV_PRESS   = 3'd0;
	localparam logic [EV_W-1:0] EV_RELEASE = 3'd1;
	localparam logic [EV_W-1:0] EV_CLICK   = 3'd2;
	localparam logic [EV_W-1:0] EV_HOLD    = 3'd3;
	localparam logic [EV_W-1:0] EV_REPEAT  = 3'd4;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_REPEAT   = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MASK     = 2'd3;

	// Configuration reset values
	localparam logic [MS_W-1:0]   DEBOUNCE_RST = 16'd10;
	localparam logic [MS_W-1:0]   HOLD_RST     = 16'd800;
	localparam logic [MS_W-1:0]   REPEAT_RST   = 16'd0;
	localparam logic [MASK_W-1:0] MASK_RST     = 8'd0;

	typedef struct packed {
		logic [MS_W-1:0]   bounce_ms;
		logic [MS_W-1:0]   hold_ms;
		logic [MS_W-1:0]   rpt_ms;
		logic [MASK_W-1:0] active_low_mask;
	} cfg_t;

	// Write command into the per-button state
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic              set_pressed;
		logic              clr_pressed;
		logic              wr_edge;
		logic              wr_down;
		logic              set_hold;
		logic              clr_hold;
		logic              wr_rpt;
		logic [TIME_W-1:0] stamp;
	} btn_wr_t;

	// Per-button state of the selected button
	typedef struct packed {
		logic              pressed;
		logic              hold_done;
		logic [TIME_W-1:0] last_edge;
		logic [TIME_W-1:0] down;
		logic [TIME_W-1:0] last_rpt;
	} btn_rd_t;

endpackage

>>> rtl/core/bed_cmp.sv
module bed_cmp (
	input  logic [bed_pkg::TIME_W-1:0] now,
	input  logic [bed_pkg::TIME_W-1:0] stamp,
	input  logic [bed_pkg::MS_W-1:0]   limit,
	output logic                       ge
);

	logic [bed_pkg::TIME_W-1:0] diff;

	// Elapsed time wraps modulo 2^32
	assign diff = now - stamp;
	assign ge   = diff >= {{(bed_pkg::TIME_W - bed_pkg::MS_W){1'b0}}, limit};

endmodule

>>> rtl/core/bed_regs.sv
module bed_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bed_pkg::btn_wr_t          wr,
	input  logic [bed_pkg::IDX_W-1:0] rd_idx,
	output bed_pkg::btn_rd_t          rd
);

	logic                       pressed_q   [bed_pkg::NUM_BUTTONS];
	logic                       hold_done_q [bed_pkg::NUM_BUTTONS];
	logic [bed_pkg::TIME_W-1:0] edge_q      [bed_pkg::NUM_BUTTONS];
	logic [bed_pkg::TIME_W-1:0] down_q      [bed_pkg::NUM_BUTTONS];
	logic [bed_pkg::TIME_W-1:0] rpt_q       [bed_pkg::NUM_BUTTONS];

	// State update, one button per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bed_pkg::NUM_BUTTONS; i++) begin
				pressed_q[i]   <= 1'b0;
				hold_done_q[i] <= 1'b0;
				edge_q[i]      <= '0;
				down_q[i]      <= '0;
				rpt_q[i]       <= '0;
			end
		end else begin
			if (wr.set_pressed)
				pressed_q[wr.idx] <= 1'b1;
			else if (wr.clr_pressed)
				pressed_q[wr.idx] <= 1'b0;
			if (wr.set_hold)
				hold_done_q[wr.idx] <= 1'b1;
			else if (wr.clr_hold)
				hold_done_q[wr.idx] <= 1'b0;
			if (wr.wr_edge)
				edge_q[wr.idx] <= wr.stamp;
			if (wr.wr_down)
				down_q[wr.idx] <= wr.stamp;
			if (wr.wr_rpt)
				rpt_q[wr.idx] <= wr.stamp;
		end
	end

	// Read port for the button under work
	always_comb begin
		rd.pressed   = pressed_q[rd_idx];
		rd.hold_done = hold_done_q[rd_idx];
		rd.last_edge = edge_q[rd_idx];
		rd.down      = down_q[rd_idx];
		rd.last_rpt  = rpt_q[rd_idx];
	end

endmodule

>>> rtl/core/bed_ctrl.sv
module bed_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bed_pkg::cfg_t              cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [bed_pkg::BTN_W-1:0]  button,
	input  logic                       level,
	input  logic [bed_pkg::TIME_W-1:0] now_ms,
	output logic [bed_pkg::IDX_W-1:0]  rd_idx,
	input  bed_pkg::btn_rd_t           rd,
	output bed_pkg::btn_wr_t           wr,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bed_pkg::EV_W-1:0]   event_res,
	output logic [bed_pkg::BTN_W-1:0]  which_button,
	output logic                       last
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EDGE_DB  = 3'd1;
	localparam logic [2:0] ST_EDGE_REL = 3'd2;
	localparam logic [2:0] ST_CLICK    = 3'd3;
	localparam logic [2:0] ST_SCAN     = 3'd4;
	localparam logic [2:0] ST_FLUSH    = 3'd5;

	localparam logic [bed_pkg::IDX_W-1:0] LAST_IDX = bed_pkg::IDX_W'(bed_pkg::NUM_BUTTONS - 1);
	localparam logic [bed_pkg::CNT_W-1:0] CNT_MAX  = bed_pkg::CNT_W'(bed_pkg::MAX_RESULTS);

	logic [2:0]                  state_q, state_d;
	logic [bed_pkg::IDX_W-1:0]   idx_q, idx_d;
	logic [bed_pkg::CNT_W-1:0]   cnt_q;
	logic                        level_q;
	logic [bed_pkg::TIME_W-1:0]  now_q;

	logic                        pend_valid_q;
	logic [bed_pkg::EV_W-1:0]    pend_ev_q;
	logic [bed_pkg::BTN_W-1:0]   pend_btn_q;
	logic                        out_valid_q;
	logic [bed_pkg::EV_W-1:0]    out_ev_q;
	logic [bed_pkg::BTN_W-1:0]   out_btn_q;
	logic                        out_last_q;

	logic [bed_pkg::TIME_W-1:0]  cmp_stamp;
	logic [bed_pkg::MS_W-1:0]    cmp_limit;
	logic                        cmp_ge;
	logic                        accept;
	logic                        act_low;
	logic                        logical;
	logic                        emit;
	logic [bed_pkg::EV_W-1:0]    emit_ev;
	logic                        flush;
	logic                        out_free;
	logic                        go;
	logic                        load;
	bed_pkg::btn_wr_t            wr_d;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign rd_idx   = idx_q;

	// Shared elapsed-time compare, operands picked by the sequencer
	always_comb begin
		case (state_q)
			ST_EDGE_DB: begin
				cmp_stamp = rd.last_edge;
				cmp_limit = cfg.bounce_ms;
			end
			ST_SCAN: begin
				cmp_stamp = rd.hold_done ? rd.last_rpt : rd.down;
				cmp_limit = rd.hold_done ? cfg.rpt_ms : cfg.hold_ms;
			end
			default: begin
				cmp_stamp = rd.down;
				cmp_limit = cfg.hold_ms;
			end
		endcase
	end

	bed_cmp u_cmp (
		.now   (now_q),
		.stamp (cmp_stamp),
		.limit (cmp_limit),
		.ge    (cmp_ge)
	);

	// Pin polarity of the selected button
	always_comb begin
		if (32'(idx_q) < 32'(bed_pkg::MASK_W))
			act_low = cfg.active_low_mask[bed_pkg::MASK_IDX_W'(idx_q)];
		else
			act_low = 1'b0;
		logical = act_low ? !level_q : level_q;
	end

	// Sequencer
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		emit        = 1'b0;
		emit_ev     = bed_pkg::EV_PRESS;
		flush       = 1'b0;
		wr_d        = '0;
		wr_d.idx    = idx_q;
		wr_d.stamp  = now_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == bed_pkg::OP_TICK) begin
						state_d = ST_SCAN;
						idx_d   = '0;
					end else if (32'(button) < 32'(bed_pkg::NUM_BUTTONS)) begin
						state_d = ST_EDGE_DB;
						idx_d   = bed_pkg::IDX_W'(button);
					end
				end
			end
			ST_EDGE_DB: begin
				state_d = ST_FLUSH;
				if (cmp_ge) begin
					wr_d.wr_edge = 1'b1;
					if (logical) begin
						wr_d.set_pressed = 1'b1;
						wr_d.wr_down     = 1'b1;
						wr_d.clr_hold    = 1'b1;
						wr_d.wr_rpt      = 1'b1;
						emit             = 1'b1;
						emit_ev          = bed_pkg::EV_PRESS;
					end else if (rd.pressed) begin
						wr_d.clr_pressed = 1'b1;
						state_d          = ST_EDGE_REL;
					end
				end
			end
			ST_EDGE_REL: begin
				emit    = 1'b1;
				emit_ev = bed_pkg::EV_RELEASE;
				state_d = cmp_ge ? ST_FLUSH : ST_CLICK;
			end
			ST_CLICK: begin
				emit    = 1'b1;
				emit_ev = bed_pkg::EV_CLICK;
				state_d = ST_FLUSH;
			end
			ST_SCAN: begin
				if (cnt_q == CNT_MAX) begin
					state_d = ST_FLUSH;
				end else begin
					if (rd.pressed && cmp_ge) begin
						if (!rd.hold_done) begin
							wr_d.set_hold = 1'b1;
							wr_d.wr_rpt   = 1'b1;
							emit          = 1'b1;
							emit_ev       = bed_pkg::EV_HOLD;
						end else if (cfg.rpt_ms != '0) begin
							wr_d.wr_rpt = 1'b1;
							emit        = 1'b1;
							emit_ev     = bed_pkg::EV_REPEAT;
						end
					end
					if (idx_q == LAST_IDX)
						state_d = ST_FLUSH;
					else
						idx_d = idx_q + 1'b1;
				end
			end
			ST_FLUSH: begin
				flush   = pend_valid_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A step that pushes into the output register waits until it is free
	assign out_free = !out_valid_q || !out_stall;
	assign go       = !((emit && pend_valid_q) || flush) || out_free;
	assign load     = go && ((emit && pend_valid_q) || flush);
	assign wr       = go ? wr_d : '0;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (go) begin
				state_q <= state_d;
				idx_q   <= idx_d;
				if (accept)
					cnt_q <= '0;
				else if (emit)
					cnt_q <= cnt_q + 1'b1;
				if (emit)
					pend_valid_q <= 1'b1;
				else if (flush)
					pend_valid_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Transaction capture, held result and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			level_q <= level;
			now_q   <= now_ms;
		end
		if (go && emit) begin
			pend_ev_q  <= emit_ev;
			pend_btn_q <= bed_pkg::BTN_W'(idx_q);
		end
		if (load) begin
			out_ev_q   <= pend_ev_q;
			out_btn_q  <= pend_btn_q;
			out_last_q <= flush;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = out_ev_q;
	assign which_button = out_btn_q;
	assign last         = out_last_q;

endmodule

>>> rtl/core/button_event_detector_unit.sv
// Button debounce and click / hold / repeat event detector.
// Input channel (in_valid / in_stall): one transaction is either a pin edge
// (op = edge, with button and raw level) or a tick that scans all buttons,
// each stamped with now_ms. Output channel (out_valid / out_stall): up to
// MAX_RESULTS events per transaction, the final event of an input carries
// last = 1; an input with no event gives nothing.
// Timing: the sequencer owns the shared 32-bit elapsed-time compare, one
// compare per cycle. An edge runs debounce, for a release then the release
// and (inside hold time) click steps, then a drain; a tick scans one button
// per cycle, then drains. in_stall is high meanwhile, so a new item waits
// until the last is done. An event is held pending until the next is found
// or the item ends, so the last flag is known. A receiver stall halts these
// steps at the next one that must push an event; the output register holds.
// Reset clears all per-button state and loads the register defaults
// (debounce 10 ms, hold 800 ms, repeat off, all buttons active high).
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// are expected only while the block is idle.
module button_event_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bed_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bed_pkg::MS_W-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [bed_pkg::BTN_W-1:0]     button,
	input  logic                          level,
	input  logic [bed_pkg::TIME_W-1:0]    now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bed_pkg::EV_W-1:0]      event_res,
	output logic [bed_pkg::BTN_W-1:0]     which_button,
	output logic                          last
);

	bed_pkg::cfg_t                 cfg_q;
	bed_pkg::btn_wr_t              wr;
	bed_pkg::btn_rd_t              rd;
	logic [bed_pkg::IDX_W-1:0]     rd_idx;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bounce_ms       <= bed_pkg::DEBOUNCE_RST;
			cfg_q.hold_ms         <= bed_pkg::HOLD_RST;
			cfg_q.rpt_ms          <= bed_pkg::REPEAT_RST;
			cfg_q.active_low_mask <= bed_pkg::MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bed_pkg::REG_DEBOUNCE: cfg_q.bounce_ms <= cfg_data;
				bed_pkg::REG_HOLD:     cfg_q.hold_ms   <= cfg_data;
				bed_pkg::REG_REPEAT:   cfg_q.rpt_ms    <= cfg_data;
				bed_pkg::REG_MASK:
					cfg_q.active_low_mask <= cfg_data[bed_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	bed_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_idx (rd_idx),
		.rd     (rd)
	);

	bed_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.button       (button),
		.level        (level),
		.now_ms       (now_ms),
		.rd_idx       (rd_idx),
		.rd           (rd),
		.wr           (wr),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_res    (event_res),
		.which_button (which_button),
		.last         (last)
	);

`ifndef SYNTH
	// A tick always occupies the sequencer for its scan
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op == bed_pkg::OP_TICK |=> in_stall)
		else $error("tick accepted without starting a scan");

	// Events are only pushed while an item is in work
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("event produced while idle");

	// Press and click always end the result list of their edge
	a_edge_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == bed_pkg::EV_PRESS || event_res == bed_pkg::EV_CLICK)
		|-> last)
		else $error("press or click not flagged as last");
`endif

endmodule
